// ===== src/ctb_pkg.sv =====
// Shared types and constants for the countdown timer bank.
// No dependencies; used by ctb_slot_bank and countdown_timer_bank_top.
package ctb_pkg;

  // Command kinds carried on the kind input
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_CREATE = 1'b1;

  // Reset value of the LED hold time, in milliseconds
  localparam logic [15:0] HOLD_RESET = 16'd500;

  // Expiry count saturates at the top of its 4-bit field
  localparam logic [3:0] EXP_MAX = 4'd15;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CREATE,
    ST_HOLD,
    ST_WALK
  } ctb_state_e;

  // Requests from the sequencer to the slot bank
  typedef struct packed {
    logic create;      // store a new timer in the next unused slot
    logic walk_start;  // begin a decrement pass over the used slots
  } bank_cmd_t;

  // Status from the slot bank to the sequencer
  typedef struct packed {
    logic full;        // every slot has been used
    logic expired;     // one slot expired in this cycle
    logic walk_done;   // the decrement pass ends in this cycle
  } bank_stat_t;

endpackage

// ===== src/ctb_slot_bank.sv =====
// Timer slot storage with a shared decrement and compare unit.
// Walks the used slots one per cycle through a registered-read memory.
// Depends on ctb_pkg.
module ctb_slot_bank #(
  parameter int TIMER_SLOTS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctb_pkg::bank_cmd_t     cmd_i,
  input  logic [15:0]            start_count_i,
  output ctb_pkg::bank_stat_t    stat_o
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

  logic [15:0]            remaining_q [TIMER_SLOTS];
  logic [15:0]            rd_data_q;
  logic [TIMER_SLOTS-1:0] live_q, live_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SLOT_W-1:0]      pidx_q, pidx_d;
  logic                   pend_q, pend_d;
  logic                   walking_q, walking_d;

  logic                   full;
  logic                   issue;
  logic                   hit;
  logic                   expire;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  logic [15:0]            wr_data;

  // Decode the walk step and the shared decrement unit
  assign full    = (used_q == SLOTS_C);
  assign issue   = walking_q && (cnt_q != used_q);
  assign hit     = pend_q && live_q[pidx_q];
  assign expire  = hit && (rd_data_q <= 16'd1);

  assign wr_en   = (cmd_i.create && !full) || hit;
  assign wr_addr = cmd_i.create ? used_q[SLOT_W-1:0] : pidx_q;
  assign wr_data = cmd_i.create ? start_count_i :
                   (expire ? 16'd0 : rd_data_q - 16'd1);

  assign stat_o.full      = full;
  assign stat_o.expired   = expire;
  assign stat_o.walk_done = walking_q && !issue;

  // Next state of the slot bookkeeping
  always_comb begin
    live_d    = live_q;
    used_d    = used_q;
    cnt_d     = cnt_q;
    pidx_d    = pidx_q;
    pend_d    = 1'b0;
    walking_d = walking_q;
    if (cmd_i.create && !full) begin
      live_d[used_q[SLOT_W-1:0]] = 1'b1;
      used_d = used_q + CNT_W'(1);
    end
    if (cmd_i.walk_start) begin
      walking_d = 1'b1;
      cnt_d     = '0;
    end
    if (issue) begin
      pend_d = 1'b1;
      pidx_d = cnt_q[SLOT_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
    end
    if (expire) begin
      live_d[pidx_q] = 1'b0;
    end
    if (walking_q && !issue) begin
      walking_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      used_q    <= '0;
      cnt_q     <= '0;
      pidx_q    <= '0;
      pend_q    <= 1'b0;
      walking_q <= 1'b0;
    end else begin
      live_q    <= live_d;
      used_q    <= used_d;
      cnt_q     <= cnt_d;
      pidx_q    <= pidx_d;
      pend_q    <= pend_d;
      walking_q <= walking_d;
    end
  end

  // Write one slot and read the next, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      remaining_q[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= remaining_q[cnt_q[SLOT_W-1:0]];
    end
  end

  // Checks on the slot bookkeeping
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SLOTS_C)
    else $error("slot count beyond bank size");

  a_no_create_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.create |-> !walking_q)
    else $error("create during decrement pass");

  a_expire_kills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire |=> !live_q[$past(pidx_q)])
    else $error("expired slot still live");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walking_q && !issue && !cmd_i.walk_start) |=> !walking_q && !pend_q)
    else $error("decrement pass did not end");

endmodule

// ===== src/countdown_timer_bank_top.sv =====
// Top level of the countdown timer bank: command handshake, LED hold logic
// and the sequencer that drives ctb_slot_bank. Depends on ctb_pkg.
//
// A command is taken when start is high and busy is low. A create command
// keeps busy high for the create state only; a tick keeps it high through the
// hold state and the walk state, whose decrement pass reads one slot per
// cycle from the slot memory. Each command gives exactly one result word,
// shown for one cycle with done_o high; the receiver cannot stall it, and a
// new command may be issued in the same cycle that a result is shown. The
// hold time may be written only while busy is low and no result is pending.
module countdown_timer_bank_top #(
  parameter int TIMER_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] start_count_i,
  input  logic [31:0] now_ms_i,
  input  logic        flash_hold_we_i,
  input  logic [15:0] flash_hold_ms_i,
  output logic        done_o,
  output logic        led_lit_o,
  output logic [3:0]  expired_now_o,
  output logic        accepted_o
);

  ctb_pkg::ctb_state_e state_q, state_d;
  ctb_pkg::bank_cmd_t  cmd;
  ctb_pkg::bank_stat_t stat;

  logic [15:0] count_q, count_d;
  logic [31:0] now_q, now_d;
  logic [15:0] hold_q;
  logic [31:0] stamp_q, stamp_d;
  logic        led_q, led_d;
  logic [3:0]  exp_q, exp_d;
  logic        done_q, done_d;
  logic        res_led_q, res_led_d;
  logic [3:0]  res_exp_q, res_exp_d;
  logic        res_acc_q, res_acc_d;
  logic [31:0] elapsed;

  assign elapsed = now_q - stamp_q;

  // Slot storage and shared decrement unit
  ctb_slot_bank #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .start_count_i (count_q),
    .stat_o        (stat)
  );

  // Sequence each command and build its result word
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    now_d     = now_q;
    stamp_d   = stamp_q;
    led_d     = led_q;
    exp_d     = exp_q;
    done_d    = 1'b0;
    res_led_d = res_led_q;
    res_exp_d = res_exp_q;
    res_acc_d = res_acc_q;
    cmd       = '0;
    case (state_q)
      ctb_pkg::ST_IDLE: begin
        if (start) begin
          count_d = start_count_i;
          now_d   = now_ms_i;
          state_d = (kind_i == ctb_pkg::KIND_CREATE) ? ctb_pkg::ST_CREATE
                                                     : ctb_pkg::ST_HOLD;
        end
      end
      ctb_pkg::ST_CREATE: begin
        cmd.create = 1'b1;
        res_acc_d  = !stat.full;
        res_led_d  = led_q;
        res_exp_d  = '0;
        done_d     = 1'b1;
        state_d    = ctb_pkg::ST_IDLE;
      end
      ctb_pkg::ST_HOLD: begin
        // drop the LED once the hold time has run out
        if (elapsed >= {16'd0, hold_q}) begin
          led_d   = 1'b0;
          stamp_d = now_q;
        end
        exp_d          = '0;
        cmd.walk_start = 1'b1;
        state_d        = ctb_pkg::ST_WALK;
      end
      ctb_pkg::ST_WALK: begin
        // relight, restamp and count on each expiry
        if (stat.expired) begin
          led_d   = 1'b1;
          stamp_d = now_q;
          if (exp_q != ctb_pkg::EXP_MAX) begin
            exp_d = exp_q + 4'd1;
          end
        end
        if (stat.walk_done) begin
          res_led_d = led_d;
          res_exp_d = exp_d;
          res_acc_d = 1'b0;
          done_d    = 1'b1;
          state_d   = ctb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ctb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctb_pkg::ST_IDLE;
      hold_q  <= ctb_pkg::HOLD_RESET;
      stamp_q <= '0;
      led_q   <= 1'b0;
      exp_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      stamp_q <= stamp_d;
      led_q   <= led_d;
      exp_q   <= exp_d;
      done_q  <= done_d;
      if (flash_hold_we_i) begin
        hold_q <= flash_hold_ms_i;
      end
    end
  end

  // Hold command fields and the result word
  always_ff @(posedge clk_i) begin
    count_q   <= count_d;
    now_q     <= now_d;
    res_led_q <= res_led_d;
    res_exp_q <= res_exp_d;
    res_acc_q <= res_acc_d;
  end

  assign busy          = (state_q != ctb_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign led_lit_o     = res_led_q;
  assign expired_now_o = res_exp_q;
  assign accepted_o    = res_acc_q;

endmodule
